FILE: hdl/vfpte_pkg.sv
// Package of the VFP transfer executor: request kinds, exit codes, decode classes,
// controller states and datapath steps, and the command and status structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package vfpte_pkg;

    typedef enum logic [1:0] {
        ACT_EXEC   = 2'd0,
        ACT_RESP   = 2'd1,
        ACT_HWRITE = 2'd2,
        ACT_HREAD  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_REQ  = 2'd0,
        KIND_FIN  = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        EXIT_FALL  = 2'd0,
        EXIT_UNSUP = 2'd1,
        EXIT_FAULT = 2'd2
    } exit_t;

    typedef enum logic [3:0] {
        OP_UNSUP,
        OP_VMOV_F,
        OP_VMOV_PAIR,
        OP_VMOV_SR,
        OP_VMOV_RS,
        OP_VMSR,
        OP_VMRS,
        OP_PUSH,
        OP_POP,
        OP_VLDR,
        OP_VSTR,
        OP_VLDM,
        OP_VSTM
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EX_A,
        S_EX_B,
        S_EX_W1,
        S_EX_W2,
        S_RS_W1,
        S_RS_W2,
        S_RS_RD,
        S_RS_W3,
        S_HWR,
        S_HRD,
        S_REQ,
        S_FIN_OK,
        S_FIN_UNSUP,
        S_FIN_FAULT
    } state_t;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_LATCH,
        STEP_EX_A,
        STEP_EX_B,
        STEP_EX_W1,
        STEP_EX_W2,
        STEP_RS_W1,
        STEP_RS_W2,
        STEP_RS_RD,
        STEP_RS_W3,
        STEP_HWR,
        STEP_HRD,
        STEP_REQ,
        STEP_FIN_OK,
        STEP_FIN_UNSUP,
        STEP_FIN_FAULT
    } step_t;

    typedef struct packed {
        step_t step;
        logic  go;
        logic  latch_exec;
    } cmd_t;

    typedef struct packed {
        logic unsup;
        logic is_mem;
        logic is_single;
        logic left_zero;
        logic mem_ok;
        logic slot_free;
    } sts_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] addr;
        logic        wr;
        logic        wide;
        logic [63:0] wdata;
        exit_t       code;
        logic [31:0] npc;
        logic [31:0] detail;
        logic [31:0] rval;
    } res_t;

    localparam logic [31:0] COND_MASK   = 32'hF0000000;
    localparam logic [31:0] NZCV_MASK   = 32'hF0000000;
    localparam logic [31:0] M_VMOV_F    = 32'h0FBF0ED0;
    localparam logic [31:0] V_VMOV_F    = 32'h0EB00A40;
    localparam logic [31:0] M_PAIR      = 32'h0FF00FD0;
    localparam logic [31:0] V_PAIR_TO   = 32'h0C400B10;
    localparam logic [31:0] V_PAIR_FROM = 32'h0C500B10;
    localparam logic [31:0] M_SR        = 32'h0FF00F7F;
    localparam logic [31:0] V_SR        = 32'h0E000A10;
    localparam logic [31:0] V_RS        = 32'h0E100A10;
    localparam logic [31:0] M_SYS       = 32'h0FFF0FFF;
    localparam logic [31:0] V_VMSR      = 32'h0EE10A10;
    localparam logic [31:0] V_VMRS      = 32'h0EF10A10;
    localparam logic [31:0] M_STACK     = 32'h0FBF0E00;
    localparam logic [31:0] V_PUSH      = 32'h0D2D0A00;
    localparam logic [31:0] V_POP       = 32'h0CBD0A00;
    localparam logic [31:0] M_LDR       = 32'h0F300E00;
    localparam logic [31:0] V_VLDR      = 32'h0D100A00;
    localparam logic [31:0] V_VSTR      = 32'h0D000A00;
    localparam logic [31:0] M_LDM       = 32'h0E100E00;
    localparam logic [31:0] V_VLDM      = 32'h0C100A00;
    localparam logic [31:0] V_VSTM      = 32'h0C000A00;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;
    localparam logic [5:0] SEL_VFP_BASE = 6'd16;
    localparam logic [5:0] SEL_FPSCR    = 6'd48;
    localparam logic [5:0] SEL_CPSR     = 6'd49;

endpackage

`default_nettype wire

FILE: hdl/vfp_transfer_executor.sv
// Top level of the VFP transfer executor: stream ports, field packing and the
// controller and datapath instances. Depends on vfpte_pkg, vfpte_ctrl, vfpte_datapath.
`default_nettype none

// Executes the ARM32 VFP transfer subset one request at a time. A request is taken
// only while the controller is idle; a result waiting in the output register does
// not block it. Execute steps through a latch, two register-read steps, two write
// steps, then the result; memory responses and host accesses are stepped likewise,
// all set by the controller stepping through one read and one write port on each
// register file. Register files reset to zero directly.
module vfp_transfer_executor
    import vfpte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // instruction_word, instruction_addr, reg_select, reg_value, mem_rdata, mem_ok,
    // mem_fault_addr, zero fill
    input  logic [199:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mem_addr, mem_is_write, mem_is_wide, mem_wdata, exit_code, next_pc,
    // exit_detail, read_value, zero fill
    output logic [199:0] m_tdata,
    // result_kind
    output logic [1:0]   m_tuser
);

    cmd_t cmd;
    sts_t sts;
    res_t res;

    vfpte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (action_t'(s_tuser)),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vfpte_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_instr  (s_tdata[31:0]),
        .in_pc     (s_tdata[63:32]),
        .in_sel    (s_tdata[69:64]),
        .in_val    (s_tdata[101:70]),
        .in_rdata  (s_tdata[165:102]),
        .in_ok     (s_tdata[166]),
        .in_faddr  (s_tdata[198:167]),
        .res_ready (m_tready),
        .res_valid (m_tvalid),
        .res       (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {4'd0, res.rval, res.detail, res.npc, res.code, res.wdata,
                      res.wide, res.wr, res.addr};

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("result kind out of range");

    a_code_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_FIN |-> m_tdata[99:98] == 2'd0)
        else $error("exit code on a non-finish result");

    a_wdata_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[97:34] == 64'd0)
        else $error("write data on a read or non-request result");

endmodule

`default_nettype wire

FILE: hdl/vfpte_datapath.sv
// Datapath of the VFP transfer executor: register files, status registers, access
// cursors, instruction decode and the result register. Steps come from vfpte_ctrl.
// Depends on vfpte_pkg.
`default_nettype none

module vfpte_datapath
    import vfpte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [31:0] in_instr,
    input  logic [31:0] in_pc,
    input  logic [5:0]  in_sel,
    input  logic [31:0] in_val,
    input  logic [63:0] in_rdata,
    input  logic        in_ok,
    input  logic [31:0] in_faddr,
    input  logic        res_ready,
    output logic        res_valid,
    output res_t        res
);

    logic [31:0] core_reg [16];
    logic [31:0] vfp_reg [32];
    logic [31:0] fp_reg, cpu_reg;
    logic [31:0] instr_reg, pc_reg;
    logic [5:0]  sel_reg;
    logic [31:0] val_reg, faddr_reg;
    logic [63:0] rdata_reg;
    logic        ok_reg;
    logic [31:0] cursor_reg, cursor_next;
    logic [5:0]  lane_reg, lane_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] tc0_reg, tc0_next, tc1_reg, tc1_next;
    logic [31:0] tv0_reg, tv0_next, tv1_reg, tv1_next;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;

    function automatic op_t classify(input logic [31:0] w);
        op_t op;
        op = OP_UNSUP;
        if ((w & COND_MASK) == COND_MASK) op = OP_UNSUP;
        else if ((w & M_VMOV_F) == V_VMOV_F) op = OP_VMOV_F;
        else if ((w & M_PAIR) == V_PAIR_TO || (w & M_PAIR) == V_PAIR_FROM) op = OP_VMOV_PAIR;
        else if ((w & M_SR) == V_SR) op = OP_VMOV_SR;
        else if ((w & M_SR) == V_RS) op = OP_VMOV_RS;
        else if ((w & M_SYS) == V_VMSR) op = OP_VMSR;
        else if ((w & M_SYS) == V_VMRS) op = OP_VMRS;
        else if ((w & M_STACK) == V_PUSH) op = OP_PUSH;
        else if ((w & M_STACK) == V_POP) op = OP_POP;
        else if ((w & M_LDR) == V_VLDR) op = OP_VLDR;
        else if ((w & M_LDR) == V_VSTR) op = OP_VSTR;
        else if ((w & M_LDM) == V_VLDM) op = OP_VLDM;
        else if ((w & M_LDM) == V_VSTM) op = OP_VSTM;
        return op;
    endfunction

    // Decode of the held instruction.
    op_t         op;
    logic [3:0]  rt, rn, vm;
    logic        dbl, hi;
    logic [7:0]  n, span_d;
    logic [8:0]  end_s;
    logic        lane_ok;
    logic [5:0]  first;
    logic        is_multi, is_single, is_store, is_load, unsup;
    logic [31:0] cnt4, disp, base;

    always_comb
    begin
        op = classify(instr_reg);
        rt = instr_reg[15:12];
        rn = instr_reg[19:16];
        vm = instr_reg[3:0];
        dbl = instr_reg[8];
        hi = instr_reg[22];
        n = instr_reg[7:0];
        span_d = {4'd0, rt} + {1'b0, n[7:1]};
        end_s = {3'd0, 1'b0, rt, hi} + {1'b0, n};
        if (n == 8'd0) lane_ok = 1'b0;
        else if (dbl) lane_ok = !hi && !n[0] && span_d <= 8'd16;
        else lane_ok = end_s <= 9'd32;
        first = dbl ? {1'b0, rt, 1'b0} : {1'b0, rt, hi};
        cnt4 = {22'd0, n, 2'b00};
        disp = {22'd0, n, 2'b00};
        is_multi = op == OP_PUSH || op == OP_POP || op == OP_VLDM || op == OP_VSTM;
        is_single = op == OP_VLDR || op == OP_VSTR;
        is_store = op == OP_PUSH || op == OP_VSTM || op == OP_VSTR;
        is_load = op == OP_POP || op == OP_VLDM || op == OP_VLDR;
        base = (rn == REG_PC) ? pc_reg + 32'd8 : tc0_reg;
        case (op)
            OP_VMOV_F:    unsup = dbl && (hi || instr_reg[5]);
            OP_VMOV_PAIR: unsup = rt == REG_PC || rn == REG_PC || instr_reg[5];
            OP_VMOV_SR,
            OP_VMOV_RS,
            OP_VMSR:      unsup = rt == REG_PC;
            OP_VMRS:      unsup = 1'b0;
            OP_PUSH,
            OP_POP:       unsup = !lane_ok;
            OP_VLDM,
            OP_VSTM:      unsup = instr_reg[24] || !instr_reg[23] || rn == REG_PC || !lane_ok;
            OP_VLDR:      unsup = dbl && hi;
            OP_VSTR:      unsup = rn == REG_PC || (dbl && hi);
            default:      unsup = 1'b1;
        endcase
    end

    logic [3:0]  core_ra, core_wa;
    logic [4:0]  vfp_ra, vfp_wa;
    logic [31:0] core_rd, vfp_rd, core_wd, vfp_wd, fp_wd, cpu_wd, hread;
    logic        core_we, vfp_we, fp_we, cpu_we, slot_free;
    logic [5:0]  sel_m16;

    assign core_rd = core_reg[core_ra];
    assign vfp_rd = vfp_reg[vfp_ra];
    assign slot_free = !out_valid_reg || res_ready;
    assign sel_m16 = sel_reg - SEL_VFP_BASE;

    always_comb
    begin
        core_ra = 4'd0;
        vfp_ra = 5'd0;
        core_we = 1'b0;
        core_wa = 4'd0;
        core_wd = 32'd0;
        vfp_we = 1'b0;
        vfp_wa = 5'd0;
        vfp_wd = 32'd0;
        fp_we = 1'b0;
        fp_wd = 32'd0;
        cpu_we = 1'b0;
        cpu_wd = 32'd0;
        cursor_next = cursor_reg;
        lane_next = lane_reg;
        left_next = left_reg;
        tc0_next = tc0_reg;
        tc1_next = tc1_reg;
        tv0_next = tv0_reg;
        tv1_next = tv1_reg;
        out_next = '0;
        out_valid_next = out_valid_reg && !res_ready;
        hread = 32'd0;
        if (sel_reg < SEL_VFP_BASE) hread = core_rd;
        else if (sel_reg < SEL_FPSCR) hread = vfp_rd;
        else if (sel_reg == SEL_FPSCR) hread = fp_reg;
        else if (sel_reg == SEL_CPSR) hread = cpu_reg;
        case (cmd.step)
            STEP_EX_A:
            begin
                if (op == OP_PUSH || op == OP_POP) core_ra = REG_SP;
                else if (op == OP_VMOV_PAIR || op == OP_VMOV_SR || op == OP_VMSR) core_ra = rt;
                else core_ra = rn;
                if (op == OP_VMOV_F) vfp_ra = dbl ? {vm, 1'b0} : {vm, instr_reg[5]};
                else if (op == OP_VMOV_PAIR) vfp_ra = {vm, 1'b0};
                else if (op == OP_VMOV_RS) vfp_ra = {rn, instr_reg[7]};
                else vfp_ra = first[4:0];
                tc0_next = core_rd;
                tv0_next = vfp_rd;
            end
            STEP_EX_B:
            begin
                core_ra = rn;
                vfp_ra = is_single ? {rt, 1'b1} : {vm, 1'b1};
                tc1_next = core_rd;
                tv1_next = vfp_rd;
            end
            STEP_EX_W1:
            begin
                if (!unsup)
                begin
                    case (op)
                        OP_VMOV_F:
                        begin
                            vfp_we = 1'b1;
                            vfp_wa = dbl ? {rt, 1'b0} : {rt, hi};
                            vfp_wd = tv0_reg;
                        end
                        OP_VMOV_PAIR:
                        begin
                            if (instr_reg[20])
                            begin
                                core_we = 1'b1;
                                core_wa = rt;
                                core_wd = tv0_reg;
                            end
                            else
                            begin
                                vfp_we = 1'b1;
                                vfp_wa = {vm, 1'b0};
                                vfp_wd = tc0_reg;
                            end
                        end
                        OP_VMOV_SR:
                        begin
                            vfp_we = 1'b1;
                            vfp_wa = {rn, instr_reg[7]};
                            vfp_wd = tc0_reg;
                        end
                        OP_VMOV_RS:
                        begin
                            core_we = 1'b1;
                            core_wa = rt;
                            core_wd = tv0_reg;
                        end
                        OP_VMSR:
                        begin
                            fp_we = 1'b1;
                            fp_wd = tc0_reg;
                        end
                        OP_VMRS:
                        begin
                            if (rt == REG_PC)
                            begin
                                cpu_we = 1'b1;
                                cpu_wd = (cpu_reg & ~NZCV_MASK) | (fp_reg & NZCV_MASK);
                            end
                            else
                            begin
                                core_we = 1'b1;
                                core_wa = rt;
                                core_wd = fp_reg;
                            end
                        end
                        OP_PUSH:
                        begin
                            core_we = 1'b1;
                            core_wa = REG_SP;
                            core_wd = tc0_reg - cnt4;
                            cursor_next = tc0_reg - cnt4;
                            lane_next = first;
                            left_next = n;
                        end
                        OP_POP,
                        OP_VLDM,
                        OP_VSTM:
                        begin
                            cursor_next = tc0_reg;
                            lane_next = first;
                            left_next = n;
                        end
                        OP_VLDR,
                        OP_VSTR:
                        begin
                            cursor_next = instr_reg[23] ? base + disp : base - disp;
                            lane_next = first;
                            left_next = dbl ? 8'd2 : 8'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            STEP_EX_W2:
            begin
                if (!unsup && op == OP_VMOV_F && dbl)
                begin
                    vfp_we = 1'b1;
                    vfp_wa = {rt, 1'b1};
                    vfp_wd = tv1_reg;
                end
                else if (!unsup && op == OP_VMOV_PAIR)
                begin
                    if (instr_reg[20])
                    begin
                        core_we = 1'b1;
                        core_wa = rn;
                        core_wd = tv1_reg;
                    end
                    else
                    begin
                        vfp_we = 1'b1;
                        vfp_wa = {vm, 1'b1};
                        vfp_wd = tc1_reg;
                    end
                end
            end
            STEP_RS_W1:
            begin
                if (cmd.go)
                begin
                    vfp_we = is_load;
                    vfp_wa = lane_reg[4:0];
                    vfp_wd = rdata_reg[31:0];
                    if (is_multi)
                    begin
                        cursor_next = cursor_reg + 32'd4;
                        lane_next = lane_reg + 6'd1;
                        left_next = left_reg - 8'd1;
                    end
                end
            end
            STEP_RS_W2:
            begin
                if (op == OP_VLDR && dbl)
                begin
                    vfp_we = 1'b1;
                    vfp_wa = lane_reg[4:0] + 5'd1;
                    vfp_wd = rdata_reg[63:32];
                end
            end
            STEP_RS_RD:
            begin
                core_ra = REG_SP;
                vfp_ra = lane_reg[4:0];
                tc0_next = core_rd;
                tv0_next = vfp_rd;
            end
            STEP_RS_W3:
            begin
                if (left_reg == 8'd0)
                begin
                    if (op == OP_POP)
                    begin
                        core_we = 1'b1;
                        core_wa = REG_SP;
                        core_wd = tc0_reg + (lane_ok ? cnt4 : 32'd0);
                    end
                    else if ((op == OP_VLDM || op == OP_VSTM) && instr_reg[21])
                    begin
                        core_we = 1'b1;
                        core_wa = rn;
                        core_wd = cursor_reg;
                    end
                end
            end
            STEP_HWR:
            begin
                if (sel_reg < SEL_VFP_BASE)
                begin
                    core_we = 1'b1;
                    core_wa = sel_reg[3:0];
                    core_wd = val_reg;
                end
                else if (sel_reg < SEL_FPSCR)
                begin
                    vfp_we = 1'b1;
                    vfp_wa = sel_m16[4:0];
                    vfp_wd = val_reg;
                end
                else if (sel_reg == SEL_FPSCR)
                begin
                    fp_we = 1'b1;
                    fp_wd = val_reg;
                end
                else if (sel_reg == SEL_CPSR)
                begin
                    cpu_we = 1'b1;
                    cpu_wd = val_reg;
                end
            end
            STEP_HRD:
            begin
                core_ra = sel_reg[3:0];
                vfp_ra = sel_m16[4:0];
                if (cmd.go)
                begin
                    out_next.kind = KIND_READ;
                    out_next.rval = hread;
                    out_valid_next = 1'b1;
                end
            end
            STEP_REQ:
            begin
                if (cmd.go)
                begin
                    out_next.kind = KIND_REQ;
                    out_next.addr = cursor_reg;
                    out_next.wr = is_store;
                    out_next.wide = is_single && dbl;
                    if (is_store)
                        out_next.wdata = (is_single && dbl) ? {tv1_reg, tv0_reg}
                                                            : {32'd0, tv0_reg};
                    out_valid_next = 1'b1;
                end
            end
            STEP_FIN_OK,
            STEP_FIN_UNSUP,
            STEP_FIN_FAULT:
            begin
                if (cmd.go)
                begin
                    out_next.kind = KIND_FIN;
                    core_we = 1'b1;
                    core_wa = REG_PC;
                    if (cmd.step == STEP_FIN_OK)
                    begin
                        out_next.code = EXIT_FALL;
                        core_wd = pc_reg + 32'd4;
                    end
                    else if (cmd.step == STEP_FIN_UNSUP)
                    begin
                        out_next.code = EXIT_UNSUP;
                        out_next.detail = instr_reg;
                        core_wd = pc_reg;
                    end
                    else
                    begin
                        out_next.code = EXIT_FAULT;
                        out_next.detail = (is_single && dbl) ? faddr_reg : cursor_reg;
                        core_wd = pc_reg;
                    end
                    out_next.npc = core_wd;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (!out_valid_next || out_valid_reg && !res_ready) out_next = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) core_reg[i] <= 32'd0;
            for (int i = 0; i < 32; i++) vfp_reg[i] <= 32'd0;
            fp_reg <= 32'd0;
            cpu_reg <= 32'd0;
            instr_reg <= 32'd0;
            pc_reg <= 32'd0;
            cursor_reg <= 32'd0;
            lane_reg <= 6'd0;
            left_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (core_we) core_reg[core_wa] <= core_wd;
            if (vfp_we) vfp_reg[vfp_wa] <= vfp_wd;
            if (fp_we) fp_reg <= fp_wd;
            if (cpu_we) cpu_reg <= cpu_wd;
            if (cmd.step == STEP_LATCH && cmd.go && cmd.latch_exec)
            begin
                instr_reg <= in_instr;
                pc_reg <= in_pc;
            end
            cursor_reg <= cursor_next;
            lane_reg <= lane_next;
            left_reg <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step == STEP_LATCH && cmd.go)
        begin
            sel_reg <= in_sel;
            val_reg <= in_val;
            rdata_reg <= in_rdata;
            ok_reg <= in_ok;
            faddr_reg <= in_faddr;
        end
        tc0_reg <= tc0_next;
        tc1_reg <= tc1_next;
        tv0_reg <= tv0_next;
        tv1_reg <= tv1_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        sts.unsup = unsup;
        sts.is_mem = is_multi || is_single;
        sts.is_single = is_single;
        sts.left_zero = left_reg == 8'd0;
        sts.mem_ok = ok_reg;
        sts.slot_free = slot_free;
    end

    assign res_valid = out_valid_reg;
    assign res = out_reg;

endmodule

`default_nettype wire

FILE: hdl/vfpte_ctrl.sv
// Controller of the VFP transfer executor: sequences the steps of each request and
// tracks whether a memory-access instruction waits for memory. Depends on vfpte_pkg.
`default_nettype none

module vfpte_ctrl
    import vfpte_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  action_t in_action,
    output logic    in_ready,
    input  sts_t    sts,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy_next = busy_reg;
        in_ready = 1'b0;
        cmd.step = STEP_NONE;
        cmd.go = 1'b1;
        cmd.latch_exec = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.step = STEP_LATCH;
                cmd.go = in_valid;
                cmd.latch_exec = in_action == ACT_EXEC && !busy_reg;
                if (in_valid)
                begin
                    case (in_action)
                        ACT_EXEC:   state_next = busy_reg ? S_IDLE : S_EX_A;
                        ACT_RESP:   state_next = busy_reg ? S_RS_W1 : S_IDLE;
                        ACT_HWRITE: state_next = S_HWR;
                        default:    state_next = S_HRD;
                    endcase
                end
            end
            S_EX_A:
            begin
                cmd.step = STEP_EX_A;
                state_next = S_EX_B;
            end
            S_EX_B:
            begin
                cmd.step = STEP_EX_B;
                state_next = S_EX_W1;
            end
            S_EX_W1:
            begin
                cmd.step = STEP_EX_W1;
                state_next = S_EX_W2;
            end
            S_EX_W2:
            begin
                cmd.step = STEP_EX_W2;
                if (sts.unsup) state_next = S_FIN_UNSUP;
                else if (sts.is_mem) state_next = S_REQ;
                else state_next = S_FIN_OK;
            end
            S_RS_W1:
            begin
                cmd.step = STEP_RS_W1;
                cmd.go = sts.mem_ok;
                state_next = sts.mem_ok ? S_RS_W2 : S_FIN_FAULT;
            end
            S_RS_W2:
            begin
                cmd.step = STEP_RS_W2;
                state_next = sts.is_single ? S_FIN_OK : S_RS_RD;
            end
            S_RS_RD:
            begin
                cmd.step = STEP_RS_RD;
                state_next = S_RS_W3;
            end
            S_RS_W3:
            begin
                cmd.step = STEP_RS_W3;
                state_next = sts.left_zero ? S_FIN_OK : S_REQ;
            end
            S_HWR:
            begin
                cmd.step = STEP_HWR;
                state_next = S_IDLE;
            end
            S_HRD:
            begin
                cmd.step = STEP_HRD;
                cmd.go = sts.slot_free;
                if (sts.slot_free) state_next = S_IDLE;
            end
            S_REQ:
            begin
                cmd.step = STEP_REQ;
                cmd.go = sts.slot_free;
                if (sts.slot_free)
                begin
                    state_next = S_IDLE;
                    busy_next = 1'b1;
                end
            end
            S_FIN_OK,
            S_FIN_UNSUP,
            S_FIN_FAULT:
            begin
                if (state_reg == S_FIN_OK) cmd.step = STEP_FIN_OK;
                else if (state_reg == S_FIN_UNSUP) cmd.step = STEP_FIN_UNSUP;
                else cmd.step = STEP_FIN_FAULT;
                cmd.go = sts.slot_free;
                if (sts.slot_free)
                begin
                    state_next = S_IDLE;
                    busy_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: test/vfp_transfer_executor_tb.sv
// Self-checking testbench of the VFP transfer executor: random stream traffic with idling,
// checked against an in-bench predictor of registers, memory requests and exit codes.
// Depends on vfpte_pkg and vfp_transfer_executor.
`timescale 1ns / 1ps

module vfp_transfer_executor_tb;
    import vfpte_pkg::*;

    typedef struct {
        action_t     act;
        logic [31:0] iword;
        logic [31:0] ipc;
        logic [5:0]  sel;
        logic [31:0] val;
        logic [63:0] rdata;
        logic        ok;
        logic [31:0] faddr;
        bit          drain;
    } request_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic [1:0]   m_tuser;

    request_t pending_q[$];
    request_t cur_req;
    res_t     outcome_q[$];
    int       errors;
    int       results_seen;
    int       gap_cnt;
    int       stall_cnt;
    bit       burst_mode;

    // Predicted architectural state.
    logic [31:0] p_core[16];
    logic [31:0] p_vfp[32];
    logic [31:0] p_fpscr;
    logic [31:0] p_cpsr;
    logic        p_busy;
    logic [31:0] p_instr;
    logic [31:0] p_pc;
    logic [31:0] p_cursor;
    logic [7:0]  p_left;
    logic [5:0]  p_lane;

    vfp_transfer_executor i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit hit(logic [31:0] w, logic [31:0] m, logic [31:0] v);
        return (w & m) == v;
    endfunction

    function automatic op_t decode_op(logic [31:0] w);
        if (w[31:28] == 4'hF) return OP_UNSUP;
        if (hit(w, M_VMOV_F, V_VMOV_F)) return OP_VMOV_F;
        if (hit(w, M_PAIR, V_PAIR_TO) || hit(w, M_PAIR, V_PAIR_FROM)) return OP_VMOV_PAIR;
        if (hit(w, M_SR, V_SR)) return OP_VMOV_SR;
        if (hit(w, M_SR, V_RS)) return OP_VMOV_RS;
        if (hit(w, M_SYS, V_VMSR)) return OP_VMSR;
        if (hit(w, M_SYS, V_VMRS)) return OP_VMRS;
        if (hit(w, M_STACK, V_PUSH)) return OP_PUSH;
        if (hit(w, M_STACK, V_POP)) return OP_POP;
        if (hit(w, M_LDR, V_VLDR)) return OP_VLDR;
        if (hit(w, M_LDR, V_VSTR)) return OP_VSTR;
        if (hit(w, M_LDM, V_VLDM)) return OP_VLDM;
        if (hit(w, M_LDM, V_VSTM)) return OP_VSTM;
        return OP_UNSUP;
    endfunction

    // Word range of a multiple transfer; returns 0 when the encoding is unsupported.
    function automatic bit word_range(logic [31:0] w, output int first, output int count);
        int n;
        int vd;
        n = w[7:0];
        vd = w[15:12];
        first = 0;
        count = 0;
        if (n == 0) return 0;
        if (w[8])
        begin
            if (w[22] || n[0] || vd + n / 2 > 16) return 0;
            first = vd * 2;
        end
        else
        begin
            first = vd * 2 + w[22];
            if (first + n > 32) return 0;
        end
        count = n;
        return 1;
    endfunction

    function automatic void push_finish(exit_t code, logic [31:0] pc, logic [31:0] detail);
        res_t r;
        p_busy = 1'b0;
        p_core[15] = (code == EXIT_FALL) ? pc + 32'd4 : pc;
        r = '0;
        r.kind = KIND_FIN;
        r.code = code;
        r.npc = p_core[15];
        r.detail = detail;
        outcome_q.push_back(r);
    endfunction

    function automatic void push_access(logic [31:0] addr, logic wr, logic wide,
                                        logic [63:0] data);
        res_t r;
        r = '0;
        r.kind = KIND_REQ;
        r.addr = addr;
        r.wr = wr;
        r.wide = wide;
        r.wdata = wr ? data : 64'd0;
        outcome_q.push_back(r);
    endfunction

    function automatic void push_word_access(op_t op);
        push_access(p_cursor, op == OP_PUSH || op == OP_VSTM, 1'b0,
                    {32'd0, p_vfp[p_lane[4:0]]});
    endfunction

    function automatic void run_instruction(logic [31:0] w, logic [31:0] pc);
        op_t         op;
        int          rt;
        int          rn;
        int          first;
        int          count;
        int          d;
        int          s;
        int          dm;
        int          lane;
        logic [31:0] base;
        logic [31:0] disp;
        op = decode_op(w);
        rt = w[15:12];
        rn = w[19:16];
        p_instr = w;
        p_pc = pc;
        case (op)
            OP_VMOV_F:
            begin
                if (w[8])
                begin
                    if (w[22] || w[5]) begin push_finish(EXIT_UNSUP, pc, w); return; end
                    d = rt * 2;
                    s = w[3:0] * 2;
                    p_vfp[d] = p_vfp[s];
                    p_vfp[d + 1] = p_vfp[s + 1];
                end
                else
                    p_vfp[(rt * 2 + w[22]) % 32] = p_vfp[(w[3:0] * 2 + w[5]) % 32];
                push_finish(EXIT_FALL, pc, 32'd0);
            end
            OP_VMOV_PAIR:
            begin
                dm = w[3:0] + w[5] * 16;
                if (rt == 15 || rn == 15 || dm >= 16) begin push_finish(EXIT_UNSUP, pc, w); return; end
                if (w[20])
                begin
                    p_core[rt] = p_vfp[dm * 2];
                    p_core[rn] = p_vfp[dm * 2 + 1];
                end
                else
                begin
                    p_vfp[dm * 2] = p_core[rt];
                    p_vfp[dm * 2 + 1] = p_core[rn];
                end
                push_finish(EXIT_FALL, pc, 32'd0);
            end
            OP_VMOV_SR, OP_VMOV_RS:
            begin
                lane = (rn * 2 + w[7]) % 32;
                if (rt == 15) begin push_finish(EXIT_UNSUP, pc, w); return; end
                if (op == OP_VMOV_SR) p_vfp[lane] = p_core[rt];
                else p_core[rt] = p_vfp[lane];
                push_finish(EXIT_FALL, pc, 32'd0);
            end
            OP_VMSR:
            begin
                if (rt == 15) begin push_finish(EXIT_UNSUP, pc, w); return; end
                p_fpscr = p_core[rt];
                push_finish(EXIT_FALL, pc, 32'd0);
            end
            OP_VMRS:
            begin
                if (rt == 15) p_cpsr = (p_cpsr & ~NZCV_MASK) | (p_fpscr & NZCV_MASK);
                else p_core[rt] = p_fpscr;
                push_finish(EXIT_FALL, pc, 32'd0);
            end
            OP_PUSH, OP_POP:
            begin
                if (!word_range(w, first, count)) begin push_finish(EXIT_UNSUP, pc, w); return; end
                if (op == OP_PUSH) p_core[13] = p_core[13] - count * 4;
                p_cursor = p_core[13];
                p_left = count;
                p_lane = first;
                p_busy = 1'b1;
                push_word_access(op);
            end
            OP_VLDM, OP_VSTM:
            begin
                if (w[24] || !w[23] || rn == 15 || !word_range(w, first, count))
                begin
                    push_finish(EXIT_UNSUP, pc, w);
                    return;
                end
                p_cursor = p_core[rn];
                p_left = count;
                p_lane = first;
                p_busy = 1'b1;
                push_word_access(op);
            end
            OP_VLDR, OP_VSTR:
            begin
                if ((op == OP_VSTR && rn == 15) || (w[8] && w[22]))
                begin
                    push_finish(EXIT_UNSUP, pc, w);
                    return;
                end
                disp = {22'd0, w[7:0], 2'b00};
                base = (rn == 15) ? pc + 32'd8 : p_core[rn];
                p_cursor = w[23] ? base + disp : base - disp;
                p_lane = w[8] ? rt * 2 : rt * 2 + w[22];
                p_left = w[8] ? 8'd2 : 8'd1;
                p_busy = 1'b1;
                if (w[8])
                    push_access(p_cursor, op == OP_VSTR, 1'b1,
                                {p_vfp[(p_lane + 1) % 32], p_vfp[p_lane[4:0]]});
                else
                    push_access(p_cursor, op == OP_VSTR, 1'b0, {32'd0, p_vfp[p_lane[4:0]]});
            end
            default: push_finish(EXIT_UNSUP, pc, w);
        endcase
    endfunction

    function automatic void run_response(logic [63:0] rdata, logic ok, logic [31:0] faddr);
        op_t op;
        int  lane;
        int  first;
        int  count;
        op = decode_op(p_instr);
        lane = p_lane[4:0];
        if (op == OP_VLDR || op == OP_VSTR)
        begin
            if (!ok) begin push_finish(EXIT_FAULT, p_pc, p_instr[8] ? faddr : p_cursor); return; end
            if (op == OP_VLDR)
            begin
                p_vfp[lane] = rdata[31:0];
                if (p_instr[8]) p_vfp[(lane + 1) % 32] = rdata[63:32];
            end
            push_finish(EXIT_FALL, p_pc, 32'd0);
            return;
        end
        if (!ok) begin push_finish(EXIT_FAULT, p_pc, p_cursor); return; end
        if (op == OP_POP || op == OP_VLDM) p_vfp[lane] = rdata[31:0];
        p_cursor = p_cursor + 32'd4;
        p_lane = p_lane + 6'd1;
        p_left = p_left - 8'd1;
        if (p_left != 0) begin push_word_access(op); return; end
        if (op == OP_POP)
        begin
            if (!word_range(p_instr, first, count)) count = 0;
            p_core[13] = p_core[13] + count * 4;
        end
        else if ((op == OP_VLDM || op == OP_VSTM) && p_instr[21])
            p_core[p_instr[19:16]] = p_cursor;
        push_finish(EXIT_FALL, p_pc, 32'd0);
    endfunction

    function automatic void predict(request_t q);
        res_t r;
        case (q.act)
            ACT_EXEC: if (!p_busy) run_instruction(q.iword, q.ipc);
            ACT_RESP: if (p_busy) run_response(q.rdata, q.ok, q.faddr);
            ACT_HWRITE:
            begin
                if (q.sel < 16) p_core[q.sel] = q.val;
                else if (q.sel < 48) p_vfp[q.sel - 16] = q.val;
                else if (q.sel == SEL_FPSCR) p_fpscr = q.val;
                else if (q.sel == SEL_CPSR) p_cpsr = q.val;
            end
            default:
            begin
                r = '0;
                r.kind = KIND_READ;
                if (q.sel < 16) r.rval = p_core[q.sel];
                else if (q.sel < 48) r.rval = p_vfp[q.sel - 16];
                else if (q.sel == SEL_FPSCR) r.rval = p_fpscr;
                else if (q.sel == SEL_CPSR) r.rval = p_cpsr;
                outcome_q.push_back(r);
            end
        endcase
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic bit can_load();
        return pending_q.size() > 0 && !(pending_q[0].drain && outcome_q.size() > 0);
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        int g;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= ACT_EXEC;
            gap_cnt <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0) burst_mode = ~burst_mode;
            if (s_tvalid && s_tready)
            begin
                predict(cur_req);
                g = draw_gap();
                if (g == 0 && can_load())
                begin
                    cur_req = pending_q.pop_front();
                    s_tdata <= {1'b0, cur_req.faddr, cur_req.ok, cur_req.rdata, cur_req.val,
                                cur_req.sel, cur_req.ipc, cur_req.iword};
                    s_tuser <= cur_req.act;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    gap_cnt <= g;
                end
            end
            else if (!s_tvalid)
            begin
                if (gap_cnt > 0)
                    gap_cnt <= gap_cnt - 1;
                else if (can_load())
                begin
                    cur_req = pending_q.pop_front();
                    s_tdata <= {1'b0, cur_req.faddr, cur_req.ok, cur_req.rdata, cur_req.val,
                                cur_req.sel, cur_req.ipc, cur_req.iword};
                    s_tuser <= cur_req.act;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        bit   nready;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_cnt <= 0;
            results_seen <= 0;
        end
        else
        begin
            nready = m_tready;
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (outcome_q.size() == 0)
                begin
                    $error("unexpected result kind=%0d", m_tuser);
                    errors++;
                end
                else
                begin
                    exp_r = outcome_q.pop_front();
                    if (m_tuser !== exp_r.kind)
                        begin $error("result_kind exp %0d got %0d", exp_r.kind, m_tuser); errors++; end
                    if (m_tdata[31:0] !== exp_r.addr)
                        begin $error("mem_addr exp %h got %h", exp_r.addr, m_tdata[31:0]); errors++; end
                    if (m_tdata[32] !== exp_r.wr)
                        begin $error("mem_is_write exp %b got %b", exp_r.wr, m_tdata[32]); errors++; end
                    if (m_tdata[33] !== exp_r.wide)
                        begin $error("mem_is_wide exp %b got %b", exp_r.wide, m_tdata[33]); errors++; end
                    if (m_tdata[97:34] !== exp_r.wdata)
                        begin $error("mem_wdata exp %h got %h", exp_r.wdata, m_tdata[97:34]); errors++; end
                    if (m_tdata[99:98] !== exp_r.code)
                        begin $error("exit_code exp %0d got %0d", exp_r.code, m_tdata[99:98]); errors++; end
                    if (m_tdata[131:100] !== exp_r.npc)
                        begin $error("next_pc exp %h got %h", exp_r.npc, m_tdata[131:100]); errors++; end
                    if (m_tdata[163:132] !== exp_r.detail)
                        begin $error("exit_detail exp %h got %h", exp_r.detail, m_tdata[163:132]); errors++; end
                    if (m_tdata[195:164] !== exp_r.rval)
                        begin $error("read_value exp %h got %h", exp_r.rval, m_tdata[195:164]); errors++; end
                    if (m_tdata[199:196] !== 4'd0)
                        begin $error("zero fill exp 0 got %h", m_tdata[199:196]); errors++; end
                end
                // One long hold-off lets the block back up and stall its input.
                if (results_seen == 300)
                begin
                    stall_cnt <= 400;
                    nready = 1'b0;
                end
                else if (draw_gap() > 0)
                begin
                    stall_cnt <= draw_gap();
                    nready = 1'b0;
                end
            end
            else if (stall_cnt > 0)
                stall_cnt <= stall_cnt - 1;
            else
                nready = 1'b1;
            m_tready <= nready;
        end
    end

    task automatic add_req(action_t act, logic [31:0] iword, logic [5:0] sel,
                           logic [31:0] val, bit drain);
        request_t q;
        q.act = act;
        q.iword = iword;
        q.ipc = $urandom();
        q.sel = sel;
        q.val = val;
        q.rdata = {$urandom(), $urandom()};
        q.ok = $urandom_range(0, 11) != 0;
        q.faddr = $urandom();
        q.drain = drain;
        pending_q.push_back(q);
    endtask

    // Builds one instruction of the given class with random free fields and queues it
    // with the memory responses that it is likely to need.
    task automatic add_sequence(op_t op);
        logic [31:0] w;
        logic [3:0]  cond;
        int          nresp;
        int          n;
        cond = ($urandom_range(0, 24) == 0) ? 4'hF : 4'($urandom_range(0, 14));
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
        nresp = 0;
        case (op)
            OP_VMOV_F:    w = V_VMOV_F | ($urandom() & ~M_VMOV_F);
            OP_VMOV_PAIR: w = ($urandom_range(0, 1) ? V_PAIR_TO : V_PAIR_FROM) | ($urandom() & ~M_PAIR);
            OP_VMOV_SR:   w = V_SR | ($urandom() & ~M_SR);
            OP_VMOV_RS:   w = V_RS | ($urandom() & ~M_SR);
            OP_VMSR:      w = V_VMSR | ($urandom() & ~M_SYS);
            OP_VMRS:      w = V_VMRS | ($urandom() & ~M_SYS);
            OP_PUSH, OP_POP:
            begin
                w = ((op == OP_PUSH) ? V_PUSH : V_POP) | ($urandom() & ~M_STACK);
                w[7:0] = n;
                nresp = n;
            end
            OP_VLDR, OP_VSTR:
            begin
                w = ((op == OP_VLDR) ? V_VLDR : V_VSTR) | ($urandom() & ~M_LDR);
                nresp = 1;
            end
            OP_VLDM, OP_VSTM:
            begin
                w = ((op == OP_VLDM) ? V_VLDM : V_VSTM) | ($urandom() & ~M_LDM);
                if ($urandom_range(0, 3) != 0) begin w[24] = 1'b0; w[23] = 1'b1; end
                w[7:0] = n;
                nresp = n;
            end
            default:
            begin
                w = $urandom();
                nresp = $urandom_range(0, 2);
            end
        endcase
        w[31:28] = cond;
        if (nresp > 40) nresp = 2;
        nresp = nresp + (($urandom_range(0, 9) == 0) ? 1 : 0);
        add_req(ACT_EXEC, w, 6'($urandom()), $urandom(), 1'b0);
        for (int i = 0; i < nresp; i++)
            add_req(ACT_RESP, $urandom(), 6'($urandom()), $urandom(), 1'b0);
    endtask

    initial
    begin
        int  r;
        op_t op;
        errors = 0;
        burst_mode = 1'b0;
        for (int i = 0; i < 16; i++) p_core[i] = '0;
        for (int i = 0; i < 32; i++) p_vfp[i] = '0;
        p_fpscr = '0;
        p_cpsr = '0;
        p_busy = 1'b0;
        p_instr = '0;
        p_pc = '0;
        p_cursor = '0;
        p_left = '0;
        p_lane = '0;

        // Directed part: register extremes, unknown selects, each class once,
        // response while idle, and an execute request while a transfer is open.
        add_req(ACT_HWRITE, 32'd0, 6'd0, 32'hFFFFFFFF, 1'b0);
        add_req(ACT_HWRITE, 32'd0, SEL_CPSR, 32'h0FFFFFFF, 1'b0);
        add_req(ACT_HWRITE, 32'd0, SEL_FPSCR, 32'hA5000000, 1'b0);
        add_req(ACT_HWRITE, 32'd0, 6'd63, 32'h12345678, 1'b0);
        add_req(ACT_HREAD, 32'd0, 6'd63, 32'd0, 1'b0);
        add_req(ACT_HREAD, 32'd0, SEL_CPSR, 32'd0, 1'b0);
        add_req(ACT_RESP, 32'd0, 6'd0, 32'd0, 1'b0);
        add_req(ACT_EXEC, V_VMRS | 32'hE000F000, 6'd0, 32'd0, 1'b0);
        add_req(ACT_HREAD, 32'd0, SEL_CPSR, 32'd0, 1'b0);
        add_req(ACT_EXEC, V_VLDR | 32'hE08F0102, 6'd0, 32'd0, 1'b0);
        add_req(ACT_EXEC, V_VMSR, 6'd0, 32'd0, 1'b0);
        add_req(ACT_RESP, 32'd0, 6'd0, 32'd0, 1'b0);
        add_req(ACT_EXEC, 32'hFFFFFFFF, 6'd0, 32'd0, 1'b0);
        for (int k = 1; k <= 12; k++) add_sequence(op_t'(k));

        while (pending_q.size() < 1950)
        begin
            r = $urandom_range(0, 99);
            if (pending_q.size() > 1000 && pending_q.size() < 1010)
                add_req(ACT_HREAD, 32'd0, 6'($urandom()), 32'd0, 1'b1);
            else if (r < 10)
                add_req(ACT_HWRITE, 32'd0, 6'($urandom()), $urandom(), 1'b0);
            else if (r < 15)
                add_req(ACT_HWRITE, 32'd0, 6'($urandom_range(0, 15)), $urandom(), 1'b0);
            else if (r < 22)
                add_req(ACT_HREAD, 32'd0, 6'($urandom()), 32'd0, 1'b0);
            else if (r < 26)
                add_req(ACT_RESP, 32'd0, 6'($urandom()), $urandom(), 1'b0);
            else if (r < 30)
                add_sequence(OP_UNSUP);
            else
            begin
                op = op_t'($urandom_range(1, 12));
                add_sequence(op);
            end
        end

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !s_tvalid && outcome_q.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && outcome_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
